// ===== hw/rtl/sd_card_spi_mode_host_macros.svh =====
// ----------------------------------------------------------------------------
// sd_card_spi_mode_host_macros
// assertion macros for the sd card spi host
// ----------------------------------------------------------------------------
`ifndef SD_CARD_SPI_MODE_HOST_MACROS_SVH
`define SD_CARD_SPI_MODE_HOST_MACROS_SVH
`ifndef SYNTHESIS
`define SDH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SDH_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDH_ASSERT(label, clk, rst, prop, msg)
`define SDH_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/sdh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdh_pkg
// shared types and constants of the sd card spi host
// ----------------------------------------------------------------------------
package sdh_pkg;
   localparam int BLOCK_BYTES_DEF = 512;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [1:0] KIND_INIT = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_BYTE = 2'd2;

   localparam logic [2:0] CSR_READY_POLL = 3'd0;
   localparam logic [2:0] CSR_IDLE_RETRY = 3'd1;
   localparam logic [2:0] CSR_OP_RETRY   = 3'd2;
   localparam logic [2:0] CSR_RESP_WAIT  = 3'd3;
   localparam logic [2:0] CSR_TOKEN_WAIT = 3'd4;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NO_IDLE     = 3'd1;
   localparam logic [2:0] ST_VOLTAGE     = 3'd2;
   localparam logic [2:0] ST_INIT_TMO    = 3'd3;
   localparam logic [2:0] ST_READ_REJ    = 3'd4;
   localparam logic [2:0] ST_BAD_TOKEN   = 3'd5;
   localparam logic [2:0] ST_TOKEN_TMO   = 3'd6;

   localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
   localparam logic [5:0] CMD_IF_COND  = 6'd8;
   localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
   localparam logic [5:0] CMD_READ     = 6'd17;
   localparam logic [5:0] CMD_OP_COND  = 6'd41;
   localparam logic [5:0] CMD_APP      = 6'd55;
   localparam logic [5:0] CMD_READ_OCR = 6'd58;

   typedef enum logic [9:0] {
      PH_IDLE  = 10'b0000000001,
      PH_WAKE  = 10'b0000000010,
      PH_READY = 10'b0000000100,
      PH_FRAME = 10'b0000001000,
      PH_RESP  = 10'b0000010000,
      PH_EXTRA = 10'b0000100000,
      PH_TOKEN = 10'b0001000000,
      PH_DATA  = 10'b0010000000,
      PH_CRC   = 10'b0100000000,
      PH_FINAL = 10'b1000000000
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] block_num;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       cs_high;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       data_last;
      logic       done_res;
      logic [2:0] status;
      logic       high_capacity;
   } rsp_type;

   typedef struct packed {
      logic [16:0] ready_poll_limit;
      logic [7:0]  idle_retry_limit;
      logic [11:0] op_cond_retry_limit;
      logic [4:0]  response_wait_bytes;
      logic [16:0] token_wait_limit;
   } cfg_type;
endpackage

// ===== hw/rtl/sdh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdh_front
// input beat queue: takes request beats in order and feeds the sequencer
// ----------------------------------------------------------------------------
module sdh_front #(
   parameter int DEPTH = sdh_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  sdh_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output sdh_pkg::req_type out_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   sdh_pkg::req_type   mem_ff [DEPTH];
   logic [AW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]        cnt_ff, cnt_in;
   logic               push, pop;

   // room when not full, or when the head beat leaves this cycle
   assign in_ready  = (cnt_ff != (AW+1)'(DEPTH)) || out_ready;
   assign push      = in_valid && in_ready;
   assign out_valid = (cnt_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end

`include "sd_card_spi_mode_host_macros.svh"
   `SDH_ASSERT(a_no_overflow, clock, reset, cnt_ff <= (AW+1)'(DEPTH), "queue overflow")
   `SDH_ASSERT(a_count_track, clock, reset, (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1), "queue count slip")
   `SDH_ASSERT(a_pop_nonempty, clock, reset, pop |-> (cnt_ff != '0), "pop from empty queue")
endmodule

// ===== hw/rtl/sdh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdh_back
// command sequencer: runs init and block read one beat at a time
// ----------------------------------------------------------------------------
module sdh_back #(
   parameter int BLOCK_BYTES = sdh_pkg::BLOCK_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  sdh_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  sdh_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output sdh_pkg::rsp_type out_data
);
   localparam int DW = $clog2(BLOCK_BYTES + 1);
   localparam int SH = $clog2(BLOCK_BYTES);

   sdh_pkg::phase_type phase_ff, phase_in;
   logic [16:0] step_ff, step_in;
   logic [11:0] retry_ff, retry_in;
   logic [2:0]  pos_ff, pos_in;
   logic [5:0]  cmd_ff, cmd_in;
   logic [31:0] arg_ff, arg_in;
   logic [7:0]  ext_ff [4];
   logic [7:0]  ext_in [4];
   logic        v2_ff, v2_in, ba_ff, ba_in;
   logic [DW-1:0] dcnt_ff, dcnt_in;
   logic        ov_ff;
   sdh_pkg::rsp_type od_ff, od_in;
   logic        take;

   logic [16:0] rp_lim, tw_lim;
   logic [7:0]  ir_lim;
   logic [11:0] op_lim;
   logic [4:0]  rw_lim;
   logic [7:0]  rx;

   assign rp_lim = (cfg.ready_poll_limit == '0) ? 17'd1 : cfg.ready_poll_limit;
   assign tw_lim = (cfg.token_wait_limit == '0) ? 17'd1 : cfg.token_wait_limit;
   assign ir_lim = (cfg.idle_retry_limit == '0) ? 8'd1 : cfg.idle_retry_limit;
   assign op_lim = (cfg.op_cond_retry_limit == '0) ? 12'd1 : cfg.op_cond_retry_limit;
   assign rw_lim = (cfg.response_wait_bytes == '0) ? 5'd1 : cfg.response_wait_bytes;
   assign rx     = in_data.rx_byte;

   assign in_ready  = !ov_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_data  = od_ff;

   function automatic logic [7:0] frame_byte(input logic [2:0] p, input logic [5:0] c,
                                             input logic [31:0] a);
      logic [7:0] b;
      case (p)
         3'd0: b = {2'b01, c};
         3'd1: b = a[31:24];
         3'd2: b = a[23:16];
         3'd3: b = a[15:8];
         3'd4: b = a[7:0];
         default: b = (c == sdh_pkg::CMD_GO_IDLE) ? 8'h95 :
                      (c == sdh_pkg::CMD_IF_COND) ? 8'h87 : 8'h01;
      endcase
      return b;
   endfunction

   always_comb begin
      logic [7:0]  r;
      logic        rsp_now;
      logic [11:0] rc;
      logic [16:0] sc;
      phase_in = phase_ff; step_in = step_ff; retry_in = retry_ff; pos_in = pos_ff;
      cmd_in = cmd_ff; arg_in = arg_ff; v2_in = v2_ff; ba_in = ba_ff; dcnt_in = dcnt_ff;
      for (int i = 0; i < 4; i++) ext_in[i] = ext_ff[i];
      od_in = '0;
      r = 8'hFF;
      rsp_now = 1'b0;
      rc = (retry_ff != '0) ? retry_ff - 1'b1 : retry_ff;
      sc = step_ff + 1'b1;

      case (in_data.kind)
         sdh_pkg::KIND_INIT: begin
            if (phase_ff == sdh_pkg::PH_IDLE) begin
               v2_in = 1'b0; ba_in = 1'b0; phase_in = sdh_pkg::PH_WAKE; step_in = '0;
               od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
            end
         end
         sdh_pkg::KIND_READ: begin
            if (phase_ff == sdh_pkg::PH_IDLE) begin
               cmd_in = sdh_pkg::CMD_READ;
               arg_in = ba_ff ? in_data.block_num : (in_data.block_num << SH);
               phase_in = sdh_pkg::PH_READY; step_in = '0;
               od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
            end
         end
         sdh_pkg::KIND_BYTE: begin
            case (phase_ff)
               sdh_pkg::PH_WAKE: begin
                  step_in = sc;
                  od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
                  if (sc >= 17'd10) begin
                     retry_in = {4'd0, ir_lim};
                     cmd_in = sdh_pkg::CMD_GO_IDLE; arg_in = '0;
                     phase_in = sdh_pkg::PH_READY; step_in = '0;
                  end
               end
               sdh_pkg::PH_READY: begin
                  if (rx == 8'hFF) begin
                     phase_in = sdh_pkg::PH_FRAME; pos_in = '0;
                     od_in.tx_valid = 1'b1; od_in.tx_byte = frame_byte(3'd0, cmd_ff, arg_ff);
                  end else begin
                     step_in = sc;
                     if (sc >= rp_lim) begin
                        rsp_now = 1'b1; r = 8'hFF;
                     end else begin
                        od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
                     end
                  end
               end
               sdh_pkg::PH_FRAME: begin
                  od_in.tx_valid = 1'b1;
                  if (pos_ff < 3'd5) begin
                     pos_in = pos_ff + 1'b1;
                     od_in.tx_byte = frame_byte(pos_ff + 1'b1, cmd_ff, arg_ff);
                  end else begin
                     phase_in = sdh_pkg::PH_RESP; step_in = '0; od_in.tx_byte = 8'hFF;
                  end
               end
               sdh_pkg::PH_RESP: begin
                  step_in = sc;
                  if (!rx[7] || sc >= {12'd0, rw_lim}) begin
                     rsp_now = 1'b1; r = rx;
                  end else begin
                     od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
                  end
               end
               sdh_pkg::PH_EXTRA: begin
                  ext_in[step_ff[1:0]] = rx;
                  step_in = sc;
                  if (sc < 17'd4) begin
                     od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
                  end else if (cmd_ff == sdh_pkg::CMD_IF_COND) begin
                     if (ext_ff[2] == 8'h01 && rx == 8'hAA) begin
                        v2_in = 1'b1; retry_in = op_lim;
                        cmd_in = sdh_pkg::CMD_APP; arg_in = '0;
                        phase_in = sdh_pkg::PH_READY; step_in = '0;
                        od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
                     end else begin
                        phase_in = sdh_pkg::PH_IDLE;
                        od_in.done_res = 1'b1; od_in.status = sdh_pkg::ST_VOLTAGE;
                     end
                  end else begin
                     ba_in = ext_ff[0][6];
                     od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
                     if (!ext_ff[0][6]) begin
                        cmd_in = sdh_pkg::CMD_BLOCKLEN; arg_in = 32'(BLOCK_BYTES);
                        phase_in = sdh_pkg::PH_READY; step_in = '0;
                     end else phase_in = sdh_pkg::PH_FINAL;
                  end
               end
               sdh_pkg::PH_TOKEN: begin
                  if (rx == 8'hFE) begin
                     phase_in = sdh_pkg::PH_DATA; dcnt_in = '0;
                     od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
                  end else if (rx == 8'hFF) begin
                     step_in = sc;
                     if (sc >= tw_lim) begin
                        phase_in = sdh_pkg::PH_IDLE;
                        od_in.done_res = 1'b1; od_in.status = sdh_pkg::ST_TOKEN_TMO;
                     end else begin
                        od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
                     end
                  end else begin
                     phase_in = sdh_pkg::PH_IDLE;
                     od_in.done_res = 1'b1; od_in.status = sdh_pkg::ST_BAD_TOKEN;
                  end
               end
               sdh_pkg::PH_DATA: begin
                  od_in.data_valid = 1'b1; od_in.data_byte = rx;
                  od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
                  dcnt_in = dcnt_ff + 1'b1;
                  if (dcnt_ff + 1'b1 >= DW'(BLOCK_BYTES)) begin
                     od_in.data_last = 1'b1; phase_in = sdh_pkg::PH_CRC; step_in = '0;
                  end
               end
               sdh_pkg::PH_CRC: begin
                  step_in = sc;
                  od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
                  if (sc >= 17'd2) phase_in = sdh_pkg::PH_FINAL;
               end
               sdh_pkg::PH_FINAL: begin
                  phase_in = sdh_pkg::PH_IDLE;
                  od_in.done_res = 1'b1; od_in.status = sdh_pkg::ST_OK;
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      if (rsp_now) begin
         od_in.tx_valid = 1'b1; od_in.tx_byte = 8'hFF;
         step_in = '0;
         phase_in = sdh_pkg::PH_READY;
         case (cmd_ff)
            sdh_pkg::CMD_GO_IDLE: begin
               retry_in = rc;
               if (r == 8'h01) begin
                  cmd_in = sdh_pkg::CMD_IF_COND; arg_in = 32'h1AA;
               end else if (rc == '0) begin
                  od_in = '0; phase_in = sdh_pkg::PH_IDLE;
                  od_in.done_res = 1'b1; od_in.status = sdh_pkg::ST_NO_IDLE;
               end else begin
                  cmd_in = sdh_pkg::CMD_GO_IDLE; arg_in = '0;
               end
            end
            sdh_pkg::CMD_IF_COND: begin
               if (r == 8'h01) phase_in = sdh_pkg::PH_EXTRA;
               else begin
                  v2_in = 1'b0; retry_in = op_lim; cmd_in = sdh_pkg::CMD_APP; arg_in = '0;
               end
            end
            sdh_pkg::CMD_APP: begin
               cmd_in = sdh_pkg::CMD_OP_COND; arg_in = v2_ff ? 32'h40000000 : 32'h0;
            end
            sdh_pkg::CMD_OP_COND: begin
               retry_in = rc;
               if (r == 8'h00) begin
                  if (v2_ff) begin
                     cmd_in = sdh_pkg::CMD_READ_OCR; arg_in = '0;
                  end else if (!ba_ff) begin
                     cmd_in = sdh_pkg::CMD_BLOCKLEN; arg_in = 32'(BLOCK_BYTES);
                  end else phase_in = sdh_pkg::PH_FINAL;
               end else if (rc == '0) begin
                  od_in = '0; phase_in = sdh_pkg::PH_IDLE;
                  od_in.done_res = 1'b1; od_in.status = sdh_pkg::ST_INIT_TMO;
               end else begin
                  cmd_in = sdh_pkg::CMD_APP; arg_in = '0;
               end
            end
            sdh_pkg::CMD_READ_OCR: begin
               if (r == 8'h00) phase_in = sdh_pkg::PH_EXTRA;
               else if (!ba_ff) begin
                  cmd_in = sdh_pkg::CMD_BLOCKLEN; arg_in = 32'(BLOCK_BYTES);
               end else phase_in = sdh_pkg::PH_FINAL;
            end
            sdh_pkg::CMD_BLOCKLEN: phase_in = sdh_pkg::PH_FINAL;
            sdh_pkg::CMD_READ: begin
               if (r != 8'h00) begin
                  od_in = '0; phase_in = sdh_pkg::PH_IDLE;
                  od_in.done_res = 1'b1; od_in.status = sdh_pkg::ST_READ_REJ;
               end else phase_in = sdh_pkg::PH_TOKEN;
            end
            default: begin
               od_in = '0; phase_in = sdh_pkg::PH_IDLE;
            end
         endcase
      end

      od_in.cs_high = (phase_in == sdh_pkg::PH_IDLE) || (phase_in == sdh_pkg::PH_WAKE) ||
                      (phase_in == sdh_pkg::PH_FINAL);
      od_in.high_capacity = ba_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdh_pkg::PH_IDLE;
         step_ff  <= '0; retry_ff <= '0; pos_ff <= '0; cmd_ff <= '0; arg_ff <= '0;
         v2_ff    <= 1'b0; ba_ff <= 1'b0; dcnt_ff <= '0; ov_ff <= 1'b0;
         for (int i = 0; i < 4; i++) ext_ff[i] <= '0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; step_ff <= step_in; retry_ff <= retry_in;
            pos_ff <= pos_in; cmd_ff <= cmd_in; arg_ff <= arg_in;
            v2_ff <= v2_in; ba_ff <= ba_in; dcnt_ff <= dcnt_in;
            for (int i = 0; i < 4; i++) ext_ff[i] <= ext_in[i];
         end
         if (take) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
      if (take) od_ff <= od_in;
   end

`include "sd_card_spi_mode_host_macros.svh"
   `SDH_ASSERT(a_done_idle, clock, reset, (take && od_in.done_res) |=> (phase_ff == sdh_pkg::PH_IDLE), "done without idle")
   `SDH_ASSERT(a_status_ok, clock, reset, (ov_ff && !od_ff.done_res) |-> (od_ff.status == sdh_pkg::ST_OK), "status without done")
   `SDH_ASSERT(a_data_count, clock, reset, dcnt_ff <= DW'(BLOCK_BYTES), "data count overrun")
endmodule

// ===== hw/rtl/sd_card_spi_mode_host.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_card_spi_mode_host
// byte-level sd card spi-mode host sequencer
// ----------------------------------------------------------------------------
// every request beat (init, block read or received card byte) yields exactly
// one response beat naming the next byte to shift and the chip-select level;
// one beat per cycle is sustained while the result side is ready, as the
// sequencer then steps once per clock; a beat is written into the two entry input
// queue, is stepped by the sequencer from the queue head and is offered from
// the sequencer's output register; with the result side stalled, three beats
// (two queued, one in the output register) are held before req_ready drops
module sd_card_spi_mode_host #(
   parameter int BLOCK_BYTES = sdh_pkg::BLOCK_BYTES_DEF,
   parameter int QUEUE_DEPTH = sdh_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sdh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sdh_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [16:0]      csr_wdata
);
   // configuration registers, reset to the power-on limits
   sdh_pkg::cfg_type cfg_ff;
   logic             q_valid, q_ready;
   sdh_pkg::req_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ready_poll_limit    <= 17'd100000;
         cfg_ff.idle_retry_limit    <= 8'd100;
         cfg_ff.op_cond_retry_limit <= 12'd1000;
         cfg_ff.response_wait_bytes <= 5'd8;
         cfg_ff.token_wait_limit    <= 17'd65535;
      end else if (csr_we) begin
         case (csr_index)
            sdh_pkg::CSR_READY_POLL: cfg_ff.ready_poll_limit    <= csr_wdata;
            sdh_pkg::CSR_IDLE_RETRY: cfg_ff.idle_retry_limit    <= csr_wdata[7:0];
            sdh_pkg::CSR_OP_RETRY:   cfg_ff.op_cond_retry_limit <= csr_wdata[11:0];
            sdh_pkg::CSR_RESP_WAIT:  cfg_ff.response_wait_bytes <= csr_wdata[4:0];
            sdh_pkg::CSR_TOKEN_WAIT: cfg_ff.token_wait_limit    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: beat queue
   sdh_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   // back: command sequencer with registered result
   sdh_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(rsp_data)
   );
endmodule
